### hdl/bdn_pkg.sv
package bdn_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int CRD_W     = 18;
    localparam int SCORE_W   = 16;
    localparam int LABEL_W   = 8;
    localparam int CFG_IDX_W = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVL_THR   = 8'd1;

    localparam logic [SCORE_W-1:0] SCORE_THR_RESET = 16'd26214;
    localparam logic [SCORE_W-1:0] OVL_THR_RESET   = 16'd32768;

    // cycles spent waiting on the overlap pipeline, minus one
    localparam logic [2:0] IOU_WAIT = 3'd4;

    typedef struct packed {
        logic signed [CRD_W-1:0] lt_x;
        logic signed [CRD_W-1:0] lt_y;
        logic signed [CRD_W-1:0] rb_x;
        logic signed [CRD_W-1:0] rb_y;
        logic [SCORE_W-1:0]      score;
        logic [LABEL_W-1:0]      label;
    } t_entry;

    typedef enum logic [1:0] {
        RD_K,
        RD_I,
        RD_J
    } t_rd_sel;

    typedef struct packed {
        logic    latch_in;
        logic    set_ovf;
        logic    k_load;
        logic    k_dec;
        logic    wr_rdata;
        logic    wr_new;
        t_rd_sel rd_sel;
        logic    i_clear;
        logic    i_inc;
        logic    load_a;
        logic    j_load;
        logic    j_inc;
        logic    set_sup;
        logic    emit_box;
        logic    emit_empty;
        logic    frame_clear;
    } t_cmd;

    typedef struct packed {
        logic keep;
        logic full;
        logic last;
        logic k_zero;
        logic rd_ge;
        logic i_end;
        logic i_sup;
        logic j_end;
        logic j_sup;
        logic hit;
        logic emitted;
    } t_stat;

endpackage

### hdl/bdn_iou.sv
module bdn_iou import bdn_pkg::*; (
    input  logic               i_clk,
    input  t_entry             i_a,
    input  t_entry             i_b,
    input  logic [SCORE_W-1:0] i_thr,
    output logic               o_hit
);

    logic signed [CRD_W-1:0] s_xl, s_xr, s_yt, s_yb;
    logic signed [CRD_W:0]   s_iw, s_ih;
    logic [CRD_W-1:0]        s_aw, s_ah, s_bw, s_bh;

    logic [16:0] r_iw, r_ih, r_aw, r_ah, r_bw, r_bh;
    logic [33:0] r_inter, r_area_a, r_area_b;
    logic [34:0] r_uni;
    logic [49:0] r_lhs, r_lhs2;
    logic [50:0] r_rhs;

    // intersection edges and box sizes
    always_comb begin
        s_xl = (i_a.lt_x > i_b.lt_x) ? i_a.lt_x : i_b.lt_x;
        s_yt = (i_a.lt_y > i_b.lt_y) ? i_a.lt_y : i_b.lt_y;
        s_xr = (i_a.rb_x < i_b.rb_x) ? i_a.rb_x : i_b.rb_x;
        s_yb = (i_a.rb_y < i_b.rb_y) ? i_a.rb_y : i_b.rb_y;
        s_iw = {s_xr[CRD_W-1], s_xr} - {s_xl[CRD_W-1], s_xl};
        s_ih = {s_yb[CRD_W-1], s_yb} - {s_yt[CRD_W-1], s_yt};
        s_aw = i_a.rb_x - i_a.lt_x;
        s_ah = i_a.rb_y - i_a.lt_y;
        s_bw = i_b.rb_x - i_b.lt_x;
        s_bh = i_b.rb_y - i_b.lt_y;
    end

    // stage 1: sizes, empty overlap forced to zero
    always_ff @(posedge i_clk) begin
        if (s_iw[CRD_W] || s_ih[CRD_W]) begin
            r_iw <= '0;
            r_ih <= '0;
        end else begin
            r_iw <= s_iw[16:0];
            r_ih <= s_ih[16:0];
        end
        r_aw <= s_aw[16:0];
        r_ah <= s_ah[16:0];
        r_bw <= s_bw[16:0];
        r_bh <= s_bh[16:0];
    end

    // stage 2: areas
    always_ff @(posedge i_clk) begin
        r_inter  <= r_iw * r_ih;
        r_area_a <= r_aw * r_ah;
        r_area_b <= r_bw * r_bh;
    end

    // stage 3: union and scaled intersection
    always_ff @(posedge i_clk) begin
        r_uni <= {1'b0, r_area_a} + {1'b0, r_area_b} - {1'b0, r_inter};
        r_lhs <= {r_inter, 16'h0000};
    end

    // stage 4: threshold times union
    always_ff @(posedge i_clk) begin
        r_rhs  <= i_thr * r_uni;
        r_lhs2 <= r_lhs;
    end

    // stage 5: compare
    always_ff @(posedge i_clk) begin
        o_hit <= {1'b0, r_lhs2} > r_rhs;
    end

endmodule

### hdl/bdn_datapath.sv
module bdn_datapath import bdn_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [15:0]          i_center_x,
    input  logic [15:0]          i_center_y,
    input  logic [15:0]          i_box_width,
    input  logic [15:0]          i_box_height,
    input  logic [SCORE_W-1:0]   i_score,
    input  logic [LABEL_W-1:0]   i_class_label,
    input  logic                 i_last_box,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic                 o_strobe,
    output logic [CRD_W-1:0]     o_left,
    output logic [CRD_W-1:0]     o_top,
    output logic [CRD_W-1:0]     o_right,
    output logic [CRD_W-1:0]     o_bottom,
    output logic [SCORE_W-1:0]   o_kept_score,
    output logic [LABEL_W-1:0]   o_kept_label,
    output logic                 o_box_valid,
    output logic                 o_overflowed,
    output logic                 o_last_result
);

    logic [SCORE_W-1:0] r_score_thr, r_ovl_thr;
    t_entry             r_new, r_rdata, r_a;
    logic               r_new_last;
    t_entry             r_mem [MAX_BOXES];
    logic [CNT_W-1:0]   r_count, r_k, r_i, r_j;
    logic               r_ovf, r_emitted;
    logic [MAX_BOXES-1:0] r_sup;

    logic signed [CRD_W-1:0] s_cx, s_cy, s_hw, s_hh;
    logic [CNT_W-1:0]     s_k_m1;
    logic [IDX_W-1:0]     s_raddr;
    t_entry               s_wdata;
    logic [MAX_BOXES-1:0] s_rem;
    logic                 s_none_left;
    logic                 s_hit;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_thr <= SCORE_THR_RESET;
            r_ovl_thr   <= OVL_THR_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_SCORE_THR) begin
                r_score_thr <= i_cfg_data;
            end
            if (i_cfg_index == REG_OVL_THR) begin
                r_ovl_thr <= i_cfg_data;
            end
        end
    end

    // decode the incoming item into corners
    always_comb begin
        s_cx = signed'({2'b00, i_center_x});
        s_cy = signed'({2'b00, i_center_y});
        s_hw = signed'({3'b000, i_box_width[15:1]});
        s_hh = signed'({3'b000, i_box_height[15:1]});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_new.lt_x  <= s_cx - s_hw;
            r_new.lt_y  <= s_cy - s_hh;
            r_new.rb_x  <= s_cx + s_hw;
            r_new.rb_y  <= s_cy + s_hh;
            r_new.score <= i_score;
            r_new.label <= i_class_label;
            r_new_last  <= i_last_box;
        end
    end

    // box store: one write and one registered read a cycle
    assign s_k_m1  = r_k - CNT_W'(1);
    assign s_wdata = i_cmd.wr_new ? r_new : r_rdata;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_K:    s_raddr = s_k_m1[IDX_W-1:0];
            RD_I:    s_raddr = r_i[IDX_W-1:0];
            RD_J:    s_raddr = r_j[IDX_W-1:0];
            default: s_raddr = r_j[IDX_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new || i_cmd.wr_rdata) begin
            r_mem[r_k[IDX_W-1:0]] <= s_wdata;
        end
        r_rdata <= r_mem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) begin
            r_a <= r_rdata;
        end
    end

    // counters, flags and suppression marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_sup     <= '0;
            r_emitted <= 1'b0;
            r_k       <= '0;
            r_i       <= '0;
            r_j       <= '0;
        end else begin
            if (i_cmd.k_load) begin
                r_k <= r_count;
            end else if (i_cmd.k_dec) begin
                r_k <= s_k_m1;
            end
            if (i_cmd.i_clear) begin
                r_i <= '0;
            end else if (i_cmd.i_inc) begin
                r_i <= r_i + CNT_W'(1);
            end
            if (i_cmd.j_load) begin
                r_j <= r_i + CNT_W'(1);
            end else if (i_cmd.j_inc) begin
                r_j <= r_j + CNT_W'(1);
            end
            if (i_cmd.frame_clear) begin
                r_count   <= '0;
                r_ovf     <= 1'b0;
                r_sup     <= '0;
                r_emitted <= 1'b0;
            end else begin
                if (i_cmd.wr_new) begin
                    r_count <= r_count + CNT_W'(1);
                end
                if (i_cmd.set_ovf) begin
                    r_ovf <= 1'b1;
                end
                if (i_cmd.set_sup) begin
                    r_sup[r_j[IDX_W-1:0]] <= 1'b1;
                end
                if (i_cmd.emit_box) begin
                    r_emitted <= 1'b1;
                end
            end
        end
    end

    // any unsuppressed box left after the current one
    always_comb begin
        for (int e = 0; e < MAX_BOXES; e++) begin
            s_rem[e] = !r_sup[e] && (CNT_W'(e) > r_i) && (CNT_W'(e) < r_count);
        end
        s_none_left = ~|s_rem;
    end

    bdn_iou u_iou (
        .i_clk (i_clk),
        .i_a   (r_a),
        .i_b   (r_rdata),
        .i_thr (r_ovl_thr),
        .o_hit (s_hit)
    );

    // status to the controller
    always_comb begin
        o_stat.keep    = r_new.score >= r_score_thr;
        o_stat.full    = r_count == CNT_W'(MAX_BOXES);
        o_stat.last    = r_new_last;
        o_stat.k_zero  = r_k == '0;
        o_stat.rd_ge   = r_rdata.score >= r_new.score;
        o_stat.i_end   = r_i == r_count;
        o_stat.i_sup   = r_sup[r_i[IDX_W-1:0]];
        o_stat.j_end   = r_j == r_count;
        o_stat.j_sup   = r_sup[r_j[IDX_W-1:0]];
        o_stat.hit     = s_hit;
        o_stat.emitted = r_emitted;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.emit_box || i_cmd.emit_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_box) begin
            o_left        <= r_a.lt_x;
            o_top         <= r_a.lt_y;
            o_right       <= r_a.rb_x;
            o_bottom      <= r_a.rb_y;
            o_kept_score  <= r_a.score;
            o_kept_label  <= r_a.label;
            o_box_valid   <= 1'b1;
            o_overflowed  <= r_ovf;
            o_last_result <= s_none_left;
        end else if (i_cmd.emit_empty) begin
            o_left        <= '0;
            o_top         <= '0;
            o_right       <= '0;
            o_bottom      <= '0;
            o_kept_score  <= '0;
            o_kept_label  <= '0;
            o_box_valid   <= 1'b0;
            o_overflowed  <= r_ovf;
            o_last_result <= 1'b1;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BOXES))
        else $error("box count beyond store size");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_new |-> r_count < CNT_W'(MAX_BOXES))
        else $error("box written into a full store");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_box_valid) |-> o_last_result)
        else $error("empty result not marked last");

    a_sup_later: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_sup |-> (r_j > r_i && r_j < r_count))
        else $error("suppression of a box not after the current one");

endmodule

### hdl/bdn_ctrl.sv
module bdn_ctrl import bdn_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_ACC       = 11'b000_0000_0010,
        S_INS_RD    = 11'b000_0000_0100,
        S_INS_CMP   = 11'b000_0000_1000,
        S_INS_NEW   = 11'b000_0001_0000,
        S_OUT_RD    = 11'b000_0010_0000,
        S_OUT_LD    = 11'b000_0100_0000,
        S_PAIR_RD   = 11'b000_1000_0000,
        S_PAIR_WAIT = 11'b001_0000_0000,
        S_PAIR_UPD  = 11'b010_0000_0000,
        S_EMIT      = 11'b100_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_wait, n_wait;

    assign busy = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= '0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_wait       = r_wait;
        o_cmd        = '0;
        o_cmd.rd_sel = RD_J;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_ACC;
                end
            end
            S_ACC: begin
                if (i_stat.keep && !i_stat.full) begin
                    o_cmd.k_load = 1'b1;
                    n_state      = S_INS_RD;
                end else begin
                    o_cmd.set_ovf = i_stat.keep;
                    if (i_stat.last) begin
                        o_cmd.i_clear = 1'b1;
                        n_state       = S_OUT_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            // walk down from the top, shifting lower scores up
            S_INS_RD: begin
                o_cmd.rd_sel = RD_K;
                n_state      = i_stat.k_zero ? S_INS_NEW : S_INS_CMP;
            end
            S_INS_CMP: begin
                if (i_stat.rd_ge) begin
                    n_state = S_INS_NEW;
                end else begin
                    o_cmd.wr_rdata = 1'b1;
                    o_cmd.k_dec    = 1'b1;
                    n_state        = S_INS_RD;
                end
            end
            S_INS_NEW: begin
                o_cmd.wr_new = 1'b1;
                if (i_stat.last) begin
                    o_cmd.i_clear = 1'b1;
                    n_state       = S_OUT_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // outer loop over sorted boxes
            S_OUT_RD: begin
                o_cmd.rd_sel = RD_I;
                if (i_stat.i_end) begin
                    o_cmd.emit_empty  = !i_stat.emitted;
                    o_cmd.frame_clear = 1'b1;
                    n_state           = S_IDLE;
                end else if (i_stat.i_sup) begin
                    o_cmd.i_inc = 1'b1;
                end else begin
                    n_state = S_OUT_LD;
                end
            end
            S_OUT_LD: begin
                o_cmd.load_a = 1'b1;
                o_cmd.j_load = 1'b1;
                n_state      = S_PAIR_RD;
            end
            // inner loop over later boxes
            S_PAIR_RD: begin
                if (i_stat.j_end) begin
                    n_state = S_EMIT;
                end else if (i_stat.j_sup) begin
                    o_cmd.j_inc = 1'b1;
                end else begin
                    n_wait  = IOU_WAIT;
                    n_state = S_PAIR_WAIT;
                end
            end
            S_PAIR_WAIT: begin
                if (r_wait == '0) begin
                    n_state = S_PAIR_UPD;
                end else begin
                    n_wait = r_wait - 3'd1;
                end
            end
            S_PAIR_UPD: begin
                o_cmd.set_sup = i_stat.hit;
                o_cmd.j_inc   = 1'b1;
                n_state       = S_PAIR_RD;
            end
            S_EMIT: begin
                o_cmd.emit_box = 1'b1;
                o_cmd.i_inc    = 1'b1;
                n_state        = S_OUT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_state == S_ACC)
        else $error("accepted item not taken into decode");

    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit_box && o_cmd.emit_empty))
        else $error("box and empty result in one cycle");

    a_wait_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAIR_UPD) |-> $past(r_state == S_PAIR_WAIT))
        else $error("overlap result used before pipeline drained");

endmodule

### hdl/box_decode_greedy_nms.sv
// Input: a kept item walks the sorted insert down to the bottom of the store, or until a
// stored box of equal or higher score stops it, shifting each box of lower score up
// (one memory read and write each); a dropped item skips the insert.
// End of frame: surviving boxes are tested against later ones in the five-stage overlap
// pipeline, suppressed boxes and skipped pairs are passed over; results never stalled.
// Synchronous active-low reset clears control, count, overflow and marks, and loads
// the threshold defaults; the box memory holds no reset value.
module box_decode_greedy_nms import bdn_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [15:0]          i_center_x,
    input  logic [15:0]          i_center_y,
    input  logic [15:0]          i_box_width,
    input  logic [15:0]          i_box_height,
    input  logic [SCORE_W-1:0]   i_score,
    input  logic [LABEL_W-1:0]   i_class_label,
    input  logic                 i_last_box,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output logic                 o_strobe,
    output logic [CRD_W-1:0]     o_left,
    output logic [CRD_W-1:0]     o_top,
    output logic [CRD_W-1:0]     o_right,
    output logic [CRD_W-1:0]     o_bottom,
    output logic [SCORE_W-1:0]   o_kept_score,
    output logic [LABEL_W-1:0]   o_kept_label,
    output logic                 o_box_valid,
    output logic                 o_overflowed,
    output logic                 o_last_result
);

    t_cmd  s_cmd;
    t_stat s_stat;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    bdn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (s_stat),
        .o_cmd   (s_cmd)
    );

    bdn_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_box_width   (i_box_width),
        .i_box_height  (i_box_height),
        .i_score       (i_score),
        .i_class_label (i_class_label),
        .i_last_box    (i_last_box),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (s_cmd),
        .o_stat        (s_stat),
        .o_strobe      (o_strobe),
        .o_left        (o_left),
        .o_top         (o_top),
        .o_right       (o_right),
        .o_bottom      (o_bottom),
        .o_kept_score  (o_kept_score),
        .o_kept_label  (o_kept_label),
        .o_box_valid   (o_box_valid),
        .o_overflowed  (o_overflowed),
        .o_last_result (o_last_result)
    );

endmodule

### tb/tb_box_decode_greedy_nms.sv
module tb_box_decode_greedy_nms import bdn_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        int          lx, ty, rx, by;
        bit [15:0]   sc;
        bit [7:0]    lb;
    } t_box;

    typedef struct packed {
        bit [17:0] l, t, r, b;
        bit [15:0] sc;
        bit [7:0]  lb;
        bit        vld, ovf, lst;
    } t_det;

    typedef struct {
        bit [15:0] cx, cy, w, h, sc;
        bit [7:0]  lb;
        bit        last;
        bit        typed;
        t_det      want;
    } t_row;

    logic i_clk, i_rst_n, start, busy;
    logic [15:0] i_center_x, i_center_y, i_box_width, i_box_height;
    logic [SCORE_W-1:0] i_score;
    logic [LABEL_W-1:0] i_class_label;
    logic i_last_box, i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0] i_cfg_data;
    logic o_strobe;
    logic [CRD_W-1:0] o_left, o_top, o_right, o_bottom;
    logic [SCORE_W-1:0] o_kept_score;
    logic [LABEL_W-1:0] o_kept_label;
    logic o_box_valid, o_overflowed, o_last_result;

    box_decode_greedy_nms dut (.*);

    // predictor state
    t_box      kept_boxes[MAX_BOXES];
    int        kept_cnt;
    bit        lost_box;
    bit [15:0] score_thr, ovl_thr;
    t_det      pending_dets[$];
    int        errors;
    int        sent;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("box_decode_greedy_nms: mismatch");
        $finish;
    end

    function automatic longint box_area(t_box x);
        return longint'(x.rx - x.lx) * longint'(x.by - x.ty);
    endfunction

    function automatic bit too_close(t_box x, t_box y);
        int xl, yt, xr, yb;
        longint inter, uni;
        xl = (x.lx > y.lx) ? x.lx : y.lx;
        yt = (x.ty > y.ty) ? x.ty : y.ty;
        xr = (x.rx < y.rx) ? x.rx : y.rx;
        yb = (x.by < y.by) ? x.by : y.by;
        inter = (xr < xl || yb < yt) ? 0 : longint'(xr - xl) * longint'(yb - yt);
        uni = box_area(x) + box_area(y) - inter;
        return (inter << 16) > longint'(ovl_thr) * uni;
    endfunction

    // update the store for one accepted item; return the frame's detections
    function automatic void predict_nms(t_row it, ref t_det dets[$]);
        int pos, hw, hh;
        bit gone[MAX_BOXES];
        t_det d;
        dets.delete();
        if (it.sc >= score_thr) begin
            if (kept_cnt >= MAX_BOXES) begin
                lost_box = 1;
            end else begin
                pos = 0;
                while (pos < kept_cnt && kept_boxes[pos].sc >= it.sc) pos++;
                for (int k = kept_cnt; k > pos; k--) kept_boxes[k] = kept_boxes[k-1];
                hw = it.w >> 1;
                hh = it.h >> 1;
                kept_boxes[pos] = '{int'(it.cx) - hw, int'(it.cy) - hh,
                                    int'(it.cx) + hw, int'(it.cy) + hh, it.sc, it.lb};
                kept_cnt++;
            end
        end
        if (!it.last) return;
        for (int k = 0; k < MAX_BOXES; k++) gone[k] = 0;
        for (int i = 0; i < kept_cnt; i++) begin
            if (gone[i]) continue;
            for (int j = i + 1; j < kept_cnt; j++)
                if (!gone[j] && too_close(kept_boxes[i], kept_boxes[j])) gone[j] = 1;
            d = '{kept_boxes[i].lx[17:0], kept_boxes[i].ty[17:0], kept_boxes[i].rx[17:0],
                  kept_boxes[i].by[17:0], kept_boxes[i].sc, kept_boxes[i].lb, 1, lost_box, 0};
            dets.insert(dets.size(), d);
        end
        if (dets.size() == 0) begin
            d = '{0, 0, 0, 0, 0, 0, 0, lost_box, 1};
            dets.insert(dets.size(), d);
        end else begin
            dets[dets.size()-1].lst = 1;
        end
        kept_cnt = 0;
        lost_box = 0;
    endfunction

    // present one item and hold it until accepted
    task automatic send_box(t_row it);
        t_det dets[$];
        i_center_x    <= it.cx;
        i_center_y    <= it.cy;
        i_box_width   <= it.w;
        i_box_height  <= it.h;
        i_score       <= it.sc;
        i_class_label <= it.lb;
        i_last_box    <= it.last;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_nms(it, dets);
        if (it.typed && it.last) begin
            pending_dets.insert(pending_dets.size(), it.want);
        end else begin
            foreach (dets[k]) pending_dets.insert(pending_dets.size(), dets[k]);
        end
        sent++;
    endtask

    task automatic hold_off(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // wait for every detection, then for the block to go quiet
    task automatic drain();
        start <= 1'b0;
        while (pending_dets.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_SCORE_THR) score_thr = val;
        else if (idx == REG_OVL_THR) ovl_thr = val;
    endtask

    // compare each strobed detection with the oldest expectation
    always @(posedge i_clk) begin
        t_det got, want;
        if (i_rst_n && o_strobe) begin
            got = '{o_left, o_top, o_right, o_bottom, o_kept_score, o_kept_label,
                    o_box_valid, o_overflowed, o_last_result};
            if (pending_dets.size() == 0) begin
                $display("%t unexpected detection %p", $realtime, got);
                errors++;
            end else begin
                want = pending_dets.pop_front();
                if (got != want) begin
                    $display("%t expected %p actual %p", $realtime, want, got);
                    errors++;
                end
            end
        end
    end

    function automatic t_row rnd_box(int ccx, int ccy, bit wild);
        t_row it;
        it = '{default: 0};
        if (wild) begin
            it.cx = 16'($urandom); it.cy = 16'($urandom);
            it.w  = 16'($urandom); it.h  = 16'($urandom);
        end else begin
            it.cx = 16'(ccx + $urandom_range(0, 64));
            it.cy = 16'(ccy + $urandom_range(0, 64));
            it.w  = 16'($urandom_range(0, 400));
            it.h  = 16'($urandom_range(0, 400));
        end
        case ($urandom_range(0, 3))
            0: it.sc = 16'(16'hFFFF - $urandom_range(0, 2));
            1: it.sc = 16'd40000;
            default: it.sc = 16'($urandom);
        endcase
        it.lb = 8'($urandom);
        return it;
    endfunction

    t_row dir_rows[] = '{
        '{100, 100, 20, 20, 26213, 1, 1, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 1}},
        '{0, 65535, 65535, 65535, 65535, 255, 1, 1,
          '{-18'sd32767, 18'sd32768, 18'sd32767, 18'sd98302, 65535, 255, 1, 0, 1}},
        '{500, 500, 0, 0, 26214, 0, 0, 0, '{default: 0}},
        '{500, 500, 0, 0, 26214, 2, 0, 0, '{default: 0}},
        '{1000, 1000, 100, 100, 40000, 3, 0, 0, '{default: 0}},
        '{1000, 1000, 100, 100, 40000, 4, 0, 0, '{default: 0}},
        '{1030, 1000, 100, 100, 50000, 5, 0, 0, '{default: 0}},
        '{5000, 5000, 64, 64, 30000, 6, 1, 0, '{default: 0}},
        '{200, 300, 33, 17, 65535, 7, 1, 0, '{default: 0}},
        '{65535, 0, 1, 65534, 65534, 128, 1, 0, '{default: 0}},
        '{10, 10, 10, 10, 0, 9, 0, 0, '{default: 0}},
        '{20, 20, 30, 30, 26000, 10, 1, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 1}},
        '{1200, 800, 300, 200, 60000, 11, 0, 0, '{default: 0}},
        '{1210, 805, 290, 210, 59000, 12, 0, 0, '{default: 0}},
        '{1700, 800, 300, 200, 58000, 13, 1, 0, '{default: 0}}
    };

    initial begin
        t_row it;
        int n, ccx, ccy, big_frames;
        bit [15:0] s_set[5], o_set[5];
        i_rst_n = 0; start = 0; i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = 0;
        i_center_x = 0; i_center_y = 0; i_box_width = 0; i_box_height = 0;
        i_score = 0; i_class_label = 0; i_last_box = 0;
        errors = 0; sent = 0; kept_cnt = 0; lost_box = 0; big_frames = 0;
        score_thr = SCORE_THR_RESET;
        ovl_thr = OVL_THR_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at the reset thresholds
        foreach (dir_rows[k]) send_box(dir_rows[k]);
        drain();

        // random frames, thresholds set at the start of each phase
        s_set = '{0, 16'hFFFF, 16'd26214, 16'd30000, 16'd12345};
        o_set = '{0, 16'hFFFF, 16'd32768, 16'd20000, 16'd50000};
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_SCORE_THR, (ph == 3) ? 16'($urandom) : s_set[ph]);
            write_reg(REG_OVL_THR, (ph == 3) ? 16'($urandom) : o_set[ph]);
            repeat (11) begin
                // one frame larger than the store, right after the idle setting change
                if (big_frames == 0 && ph == 2) begin
                    n = $urandom_range(65, 70);
                    big_frames++;
                    write_reg(REG_SCORE_THR, 16'd0);
                end else begin
                    n = $urandom_range(1, 8);
                end
                ccx = $urandom_range(0, 65000);
                ccy = $urandom_range(0, 65000);
                for (int k = 0; k < n; k++) begin
                    it = rnd_box(ccx, ccy, $urandom_range(0, 9) == 0);
                    it.last = (k == n - 1);
                    send_box(it);
                    if (sent < 300 && $urandom_range(0, 3) == 0)
                        hold_off($urandom_range(1, 17));
                end
            end
            // let every detection come back before the next setting
            drain();
        end

        while (pending_dets.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("box_decode_greedy_nms: match");
        end else begin
            $display("box_decode_greedy_nms: mismatch");
        end
        $finish;
    end
endmodule

### sim.f
hdl/bdn_pkg.sv
hdl/bdn_iou.sv
hdl/bdn_datapath.sv
hdl/bdn_ctrl.sv
hdl/box_decode_greedy_nms.sv
tb/tb_box_decode_greedy_nms.sv
